// File: src/rge_pkg.sv
// ----------------------------------------------------------------------------
// rge_pkg
// Shared types and constants of the random graph edge generator.
// ----------------------------------------------------------------------------
package rge_pkg;

  // graph size
  localparam int MaxNodes = 2008;
  localparam int MinNodes = 2000;
  localparam int NodeSpan = MaxNodes - MinNodes;
  localparam int SpanW    = $clog2(NodeSpan + 1);
  localparam int NodeW    = 12;
  localparam int WordCntW = 16;

  // twister geometry
  localparam int TwN  = 312;
  localparam int TwM  = 156;
  localparam int IdxW = 9;

  localparam logic [63:0] TwMatrix = 64'hB5026F5AA96619E9;
  localparam logic [63:0] TwMult   = 64'd6364136223846793005;

  // command codes
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_NEXT = 1'b1
  } cmd_t;

  // one queued item
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] size_word;
    logic [63:0] seed_value;
  } item_t;

  // queue to back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  // tempering of one generator word
  function automatic logic [63:0] temper(input logic [63:0] w);
    logic [63:0] x;
    x = w;
    x = x ^ ((x >> 29) & 64'h5555555555555555);
    x = x ^ ((x << 17) & 64'h71D67FFFEDA60000);
    x = x ^ ((x << 37) & 64'hFFF7EEE000000000);
    x = x ^ (x >> 43);
    return x;
  endfunction

endpackage

// File: src/rge_front.sv
// ----------------------------------------------------------------------------
// rge_front
// Input stage: takes words, tags the command and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rge_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [31:0]         in_size_word,
  input  logic [63:0]         in_seed_value,
  output rge_pkg::queue_out_t q_out,
  input  logic                q_take
);

  rge_pkg::item_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push, pop;
  rge_pkg::item_t in_item;

  // classify incoming word
  always_comb begin
    in_item.cmd        = in_command ? rge_pkg::CMD_NEXT : rge_pkg::CMD_LOAD;
    in_item.size_word  = in_size_word;
    in_item.seed_value = in_seed_value;
  end

  assign in_stall    = (count_r == 2'd2);
  assign push        = in_valid && !in_stall;
  assign pop         = q_take && (count_r != 2'd0);
  assign q_out.valid = (count_r != 2'd0);
  assign q_out.item  = slot_r[rd_ptr_r];

  // advance pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// File: src/rge_back.sv
// ----------------------------------------------------------------------------
// rge_back
// Execution stage: seeds and twists the generator table, tracks the edge
// word count and drives the output register.
// ----------------------------------------------------------------------------
module rge_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rge_pkg::queue_out_t q_in,
  output logic                q_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_edge_bits,
  output logic [15:0]         out_word_index,
  output logic                out_last_word
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LD_MUL = 11'b00000000010,
    S_LD_ADD = 11'b00000000100,
    S_SZ_MUL = 11'b00000001000,
    S_SZ_FIN = 11'b00000010000,
    S_TW_PRE = 11'b00000100000,
    S_TW_LD  = 11'b00001000000,
    S_TW_RD  = 11'b00010000000,
    S_TW_WR  = 11'b00100000000,
    S_OUT_RD = 11'b01000000000,
    S_OUT_WR = 11'b10000000000
  } state_t;

  localparam logic [rge_pkg::IdxW-1:0] LastIdx = rge_pkg::IdxW'(rge_pkg::TwN - 1);
  localparam logic [rge_pkg::IdxW-1:0] EndPos  = rge_pkg::IdxW'(rge_pkg::TwN);
  localparam logic [rge_pkg::IdxW-1:0] MIdx    = rge_pkg::IdxW'(rge_pkg::TwM);
  localparam logic [rge_pkg::SpanW:0]  SpanV   = (rge_pkg::SpanW+1)'(rge_pkg::NodeSpan);
  localparam logic [rge_pkg::NodeW-1:0] MinV   = rge_pkg::NodeW'(rge_pkg::MinNodes);
  localparam logic [32:0]              Recip   = 33'((64'd1 << 32) / rge_pkg::NodeSpan);

  state_t state_r, state_nxt;

  logic [63:0] mem [rge_pkg::TwN];
  logic [63:0] rd_a_r, rd_b_r;
  logic [rge_pkg::IdxW-1:0] addr_a, addr_b, waddr;
  logic [63:0] wdata;
  logic        we;

  logic [rge_pkg::IdxW-1:0]      idx_r, idx_nxt;
  logic [rge_pkg::IdxW-1:0]      pos_r, pos_nxt;
  logic [rge_pkg::WordCntW-1:0]  emitted_r, emitted_nxt;
  logic [rge_pkg::WordCntW-1:0]  total_r, total_nxt;
  logic [rge_pkg::NodeW-1:0]     nodes_r, nodes_nxt;
  logic [63:0]                   w_r, w_nxt;
  logic [63:0]                   cur_r, cur_nxt;
  logic [63:0]                   p0_r;
  logic [31:0]                   p1_r, p2_r;
  logic [23:0]                   prod_r;

  // remainder unit
  logic [31:0]                size_r;
  logic [31:0]                quo_r;
  logic [rge_pkg::SpanW:0]    rem_full_r;
  logic [rge_pkg::SpanW-1:0]  rem_r;
  logic [64:0]                recip_prod;
  logic [32:0]                quo_span;

  logic [63:0] mix, seed_word, twist_y, twist_v, tempered;
  logic [22:0] edge_cnt;
  logic [17:0] word_cnt;
  logic        start_load, load_out;
  logic        out_valid_r;
  logic [31:0] out_bits_r;
  logic [15:0] out_idx_r;
  logic        out_last_r;

  assign q_take     = (state_r == S_IDLE) && q_in.valid &&
                      ((q_in.item.cmd == rge_pkg::CMD_LOAD) || !out_valid_r);
  assign start_load = q_take && (q_in.item.cmd == rge_pkg::CMD_LOAD);

  // seeding arithmetic
  assign mix       = w_r ^ (w_r >> 62);
  assign seed_word = p0_r + {p1_r + p2_r, 32'd0} + {55'd0, idx_r};

  // twist arithmetic
  assign twist_y = {cur_r[63:31], rd_a_r[30:0]};
  assign twist_v = rd_b_r ^ (twist_y >> 1) ^ (twist_y[0] ? rge_pkg::TwMatrix : 64'd0);
  assign tempered = rge_pkg::temper(rd_a_r);

  // edge word count
  assign edge_cnt = prod_r[23:1];
  assign word_cnt = 18'((24'(edge_cnt) + 24'd31) >> 5);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    emitted_nxt = emitted_r;
    total_nxt   = total_r;
    nodes_nxt   = nodes_r;
    w_nxt       = w_r;
    cur_nxt     = cur_r;
    addr_a      = pos_r;
    addr_b      = '0;
    we          = 1'b0;
    waddr       = idx_r;
    wdata       = seed_word;
    load_out    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_take) begin
          if (q_in.item.cmd == rge_pkg::CMD_LOAD) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = q_in.item.seed_value;
            w_nxt     = q_in.item.seed_value;
            idx_nxt   = rge_pkg::IdxW'(1);
            state_nxt = S_LD_MUL;
          end else if (emitted_r >= total_r) begin
            state_nxt = S_IDLE;
          end else if (pos_r == EndPos) begin
            state_nxt = S_TW_PRE;
          end else begin
            state_nxt = S_OUT_RD;
          end
        end
      end
      S_LD_MUL: state_nxt = S_LD_ADD;
      S_LD_ADD: begin
        we    = 1'b1;
        w_nxt = seed_word;
        if (idx_r == LastIdx) begin
          state_nxt = S_SZ_MUL;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LD_MUL;
        end
      end
      S_SZ_MUL: begin
        nodes_nxt = MinV + rge_pkg::NodeW'(rem_r);
        state_nxt = S_SZ_FIN;
      end
      S_SZ_FIN: begin
        total_nxt   = (word_cnt > 18'hFFFF) ? 16'hFFFF : word_cnt[15:0];
        emitted_nxt = '0;
        pos_nxt     = EndPos;
        state_nxt   = S_IDLE;
      end
      S_TW_PRE: begin
        addr_a    = '0;
        idx_nxt   = '0;
        state_nxt = S_TW_LD;
      end
      S_TW_LD: begin
        cur_nxt   = rd_a_r;
        state_nxt = S_TW_RD;
      end
      S_TW_RD: begin
        addr_a    = (idx_r == LastIdx) ? '0 : idx_r + 1'b1;
        addr_b    = (idx_r < MIdx) ? idx_r + MIdx : idx_r - MIdx;
        state_nxt = S_TW_WR;
      end
      S_TW_WR: begin
        we      = 1'b1;
        wdata   = twist_v;
        cur_nxt = rd_a_r;
        if (idx_r == LastIdx) begin
          pos_nxt   = '0;
          state_nxt = S_OUT_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_TW_RD;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_WR;
      S_OUT_WR: begin
        load_out    = 1'b1;
        pos_nxt     = pos_r + 1'b1;
        emitted_nxt = emitted_r + 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      emitted_r <= '0;
      total_r   <= '0;
      nodes_r   <= MinV;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      emitted_r <= emitted_nxt;
      total_r   <= total_nxt;
      nodes_r   <= nodes_nxt;
    end
  end

  // working registers and partial products
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    w_r    <= w_nxt;
    cur_r  <= cur_nxt;
    p0_r   <= {32'd0, mix[31:0]} * {32'd0, rge_pkg::TwMult[31:0]};
    p1_r   <= 32'(mix[63:32] * rge_pkg::TwMult[31:0]);
    p2_r   <= 32'(mix[31:0] * rge_pkg::TwMult[63:32]);
    prod_r <= 24'(nodes_nxt) * 24'(nodes_nxt - 1'b1);
  end

  // generator table
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // size remainder by reciprocal: estimate quotient, subtract, correct once
  assign recip_prod = 65'(size_r) * 65'(Recip);
  assign quo_span   = 33'(quo_r) * 33'(SpanV);
  always_ff @(posedge clk) begin
    if (start_load) begin
      size_r <= q_in.item.size_word;
    end
    quo_r      <= recip_prod[63:32];
    rem_full_r <= (rge_pkg::SpanW+1)'({1'b0, size_r} - quo_span);
    rem_r      <= rge_pkg::SpanW'((rem_full_r >= SpanV) ? rem_full_r - SpanV : rem_full_r);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bits_r <= tempered[31:0];
      out_idx_r  <= emitted_r;
      out_last_r <= (emitted_r + 1'b1 == total_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_bits  = out_bits_r;
  assign out_word_index = out_idx_r;
  assign out_last_word  = out_last_r;

  // checks
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emitted_r <= total_r) else $error("emitted words beyond total");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= EndPos) else $error("table position out of range");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_WR) |-> !out_valid_r) else $error("output overwritten");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_bits_r)))
    else $error("stalled word changed");

endmodule

// File: src/random_graph_edge_generator.sv
// ----------------------------------------------------------------------------
// random_graph_edge_generator
// Top level: input queue and generator back end.
// ----------------------------------------------------------------------------
// A load word sets the node count and seeds the 312-entry generator table;
// seeding goes entry by entry (one 64-bit multiply split into three 32-bit
// partial products, then a sum) and yields no output. Each next word then
// gives one 32-bit edge word, read from a table with two read ports and
// loaded into the output register, until the word count set by the load is
// reached; later next words give none. A next word waits until the output
// register is empty, so a new one is not taken while the last edge word is
// still held there. The first next word after a load, and every 312th after
// it, first regenerates the whole table. A two-entry input queue lets the
// source run ahead while the back end is busy or the output is stalled.
module random_graph_edge_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_size_word,
  input  logic [63:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_edge_bits,
  output logic [15:0] out_word_index,
  output logic        out_last_word
);

  rge_pkg::queue_out_t q_out;
  logic                q_take;

  // accept and queue words
  rge_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_size_word  (in_size_word),
    .in_seed_value (in_seed_value),
    .q_out         (q_out),
    .q_take        (q_take)
  );

  // seed, twist and emit
  rge_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_in           (q_out),
    .q_take         (q_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_edge_bits  (out_edge_bits),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

endmodule
